// ===== hdl/pea_pkg.sv =====
`default_nettype none

package pea_pkg;

  localparam int PAGE_W = 32;
  localparam int GROWTH_DIVISOR = 3;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_GREW      = 3'd1;
  localparam logic [2:0] ST_DOUBLE    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  // slots of the index bundle that rides along with the scan token
  localparam int IX_POS  = 0;
  localparam int IX_FIT  = 1;
  localparam int IX_NXT  = 2;
  localparam int IX_PRV  = 3;
  localparam int IX_FREE = 4;
  localparam int IX_N    = 5;

  typedef struct packed {
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] len;
    logic [PAGE_W-1:0] stamp;
  } ext_t;

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] id;
    logic [PAGE_W-1:0] n;
  } qry_t;

  typedef struct packed {
    logic              live;
    logic              fit_found;
    ext_t              fit;
    logic              nxt_found;
    logic [PAGE_W-1:0] nxt_start;
    logic [PAGE_W-1:0] nxt_len;
    logic              prv_found;
    logic [PAGE_W-1:0] prv_start;
    logic [PAGE_W-1:0] prv_len;
    logic              free_found;
  } scan_t;

endpackage

`default_nettype wire

// ===== hdl/pea_div.sv =====
`default_nettype none

// divide by a constant: quotient = (x * ceil(2^SH / DIVISOR)) >> SH,
// exact for every PAGE_W-bit x; one registered multiply
module pea_div #(
  parameter int DIVISOR = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pea_pkg::PAGE_W-1:0] dividend,
  output logic                       done,
  output logic [pea_pkg::PAGE_W-1:0] quotient
);
  import pea_pkg::*;

  localparam int SH = PAGE_W + $clog2(DIVISOR);
  localparam int PW = 2 * PAGE_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PW-1:0] prod;

  assign prod = PW'(dividend) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= PAGE_W'(prod >> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (start) begin
      done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pea_cell.sv =====
`default_nettype none

// one table entry; folds itself into the passing scan token
module pea_cell #(
  parameter int IW = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pea_pkg::qry_t                      qry,
  input  pea_pkg::scan_t                     tok_in,
  input  logic [pea_pkg::IX_N-1:0][IW-1:0]   ix_in,
  input  logic                               wr_set,
  input  logic                               wr_clr,
  input  pea_pkg::ext_t                      wr_ext,
  output pea_pkg::scan_t                     tok_out,
  output logic [pea_pkg::IX_N-1:0][IW-1:0]   ix_out
);
  import pea_pkg::*;

  ext_t                  ent;
  logic                  valid;
  scan_t                 tok_next;
  logic [IX_N-1:0][IW-1:0] ix_next;
  logic                  fit_ok;
  logic                  fit_better;
  logic                  upper;

  always_comb begin
    tok_next   = tok_in;
    ix_next    = ix_in;
    fit_ok     = valid && (ent.len >= qry.n);
    fit_better = !tok_in.fit_found || (ent.len < tok_in.fit.len) ||
                 ((ent.len == tok_in.fit.len) && (ent.stamp > tok_in.fit.stamp));
    upper      = (ent.start >= qry.id);
    if (fit_ok && fit_better) begin
      tok_next.fit_found = 1'b1;
      tok_next.fit       = ent;
      ix_next[IX_FIT]    = ix_in[IX_POS];
    end
    if (valid && upper && (!tok_in.nxt_found || ent.start < tok_in.nxt_start)) begin
      tok_next.nxt_found = 1'b1;
      tok_next.nxt_start = ent.start;
      tok_next.nxt_len   = ent.len;
      ix_next[IX_NXT]    = ix_in[IX_POS];
    end
    if (valid && !upper && (!tok_in.prv_found || ent.start > tok_in.prv_start)) begin
      tok_next.prv_found = 1'b1;
      tok_next.prv_start = ent.start;
      tok_next.prv_len   = ent.len;
      ix_next[IX_PRV]    = ix_in[IX_POS];
    end
    if (!valid && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      ix_next[IX_FREE]    = ix_in[IX_POS];
    end
    ix_next[IX_POS] = IW'(ix_in[IX_POS] + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (wr_set) begin
      ent <= wr_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_set) begin
      valid <= 1'b1;
    end else if (wr_clr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
      ix_out  <= '0;
    end else begin
      tok_out <= tok_next;
      ix_out  <= ix_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/page_extent_allocator.sv =====
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, opcode, page_id,      | request in
//         | page_count                                |
// out     | out_valid, out_stall, first_page, status, | result out
//         | total_pages_now                           |
//
// One request at a time: the next request is taken only after the block returns
// to idle from its output step. The scan token starts in the cycle after the
// transfer and walks the cell chain, one cell per cycle; the capture, multiply,
// evaluate and output steps then follow in that order.
// Reset clears all valid bits, total_pages and the stamp counter at once; no
// clearing pass. A result held by out_stall keeps the block in its last step.
`default_nettype none

module page_extent_allocator #(
  parameter int MAX_EXTENTS = 64,
  parameter int GROWTH_UNIT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] page_id,
  input  logic [31:0] page_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] first_page,
  output logic [2:0]  status,
  output logic [31:0] total_pages_now
);
  import pea_pkg::*;

  localparam int IW   = $clog2(MAX_EXTENTS);
  localparam int GW   = $clog2(GROWTH_UNIT + 1);
  localparam int INCW = PAGE_W + 2;   // growth step stays below 2^33

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_EVAL = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  qry_t              q;
  scan_t             scan_q;
  logic [IX_N-1:0][IW-1:0] ix_q;
  logic              scan_done;
  logic              launch;
  logic [PAGE_W-1:0] total_pages;
  logic [PAGE_W-1:0] stamp_counter;
  logic [INCW-1:0]   inc;
  logic [PAGE_W-1:0] res_first;
  logic [2:0]        res_status;

  logic accept_in;
  logic out_free;

  // cell chain
  scan_t                    tok_chain [MAX_EXTENTS+1];
  logic [IX_N-1:0][IW-1:0]  ix_chain  [MAX_EXTENTS+1];
  logic [MAX_EXTENTS-1:0]   wr_set_v;
  logic [MAX_EXTENTS-1:0]   wr_clr_v;
  ext_t                     wr_ext;

  // growth dividers
  logic              div_a_done;
  logic              div_b_done;
  logic [PAGE_W-1:0] div_a_q;
  logic [PAGE_W-1:0] div_b_q;
  logic [PAGE_W:0]   a_p1;
  logic [PAGE_W:0]   amax;

  // evaluation
  logic              set_en;
  logic [IW-1:0]     set_idx;
  logic              clr_a_en;
  logic [IW-1:0]     clr_a_idx;
  logic              clr_b_en;
  logic [IW-1:0]     clr_b_idx;
  logic              grow_en;
  logic [PAGE_W-1:0] ev_first;
  logic [2:0]        ev_status;
  logic [PAGE_W+2:0] grow_sum;
  logic [PAGE_W:0]   rel_end;
  logic [PAGE_W:0]   prv_end;
  logic              mrg_n;
  logic              mrg_p;
  logic              have_slot;
  logic [IW-1:0]     slot;

  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // token enters cell 0 the cycle after the transfer, once q holds the request
  always_comb begin
    tok_chain[0]      = '0;
    tok_chain[0].live = launch;
    ix_chain[0]       = '0;
  end

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    pea_cell #(.IW(IW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .qry    (q),
      .tok_in (tok_chain[i]),
      .ix_in  (ix_chain[i]),
      .wr_set (wr_set_v[i]),
      .wr_clr (wr_clr_v[i]),
      .wr_ext (wr_ext),
      .tok_out(tok_chain[i+1]),
      .ix_out (ix_chain[i+1])
    );
    assign wr_set_v[i] = set_en && (set_idx == IW'(i));
    assign wr_clr_v[i] = (clr_a_en && (clr_a_idx == IW'(i))) ||
                         (clr_b_en && (clr_b_idx == IW'(i)));
  end

  // n / unit and total / (3 * unit), both started at the request transfer
  pea_div #(.DIVISOR(GROWTH_UNIT)) u_div_a (
    .clk     (clk),
    .rst     (rst),
    .start   (accept_in),
    .dividend(page_count),
    .done    (div_a_done),
    .quotient(div_a_q)
  );

  pea_div #(.DIVISOR(GROWTH_UNIT * GROWTH_DIVISOR)) u_div_b (
    .clk     (clk),
    .rst     (rst),
    .start   (accept_in),
    .dividend(total_pages),
    .done    (div_b_done),
    .quotient(div_b_q)
  );

  assign a_p1 = {1'b0, div_a_q} + 1'b1;
  assign amax = (a_p1 > {1'b0, div_b_q}) ? a_p1 : {1'b0, div_b_q};

  // decide what the request does; writes fire only in S_EVAL
  always_comb begin
    set_en    = 1'b0;
    set_idx   = '0;
    clr_a_en  = 1'b0;
    clr_a_idx = '0;
    clr_b_en  = 1'b0;
    clr_b_idx = '0;
    grow_en   = 1'b0;
    wr_ext    = '0;
    ev_first  = '0;
    ev_status = ST_OK;
    have_slot = 1'b0;
    slot      = '0;
    grow_sum  = {3'b000, total_pages} + {1'b0, inc};
    rel_end   = {1'b0, q.id} + {1'b0, q.n};
    prv_end   = {1'b0, scan_q.prv_start} + {1'b0, scan_q.prv_len};
    mrg_n     = scan_q.nxt_found && ({1'b0, scan_q.nxt_start} == rel_end);
    mrg_p     = scan_q.prv_found && (prv_end == {1'b0, q.id});
    wr_ext.stamp = stamp_counter;

    if (q.op == OP_ALLOC) begin
      if (scan_q.fit_found) begin
        // best fit: hand out the head, keep the tail as a fresh extent
        ev_first = scan_q.fit.start;
        if (scan_q.fit.len != q.n) begin
          set_en       = 1'b1;
          set_idx      = ix_q[IX_FIT];
          wr_ext.start = scan_q.fit.start + q.n;
          wr_ext.len   = scan_q.fit.len - q.n;
        end else begin
          clr_a_en  = 1'b1;
          clr_a_idx = ix_q[IX_FIT];
        end
      end else if (grow_sum[PAGE_W+2:PAGE_W] != 3'b000) begin
        ev_status = ST_EXHAUSTED;
      end else if (!scan_q.free_found) begin
        ev_status = ST_FULL;
      end else begin
        // grow; new space past the request is a separate extent
        ev_status    = ST_GREW;
        ev_first     = total_pages;
        grow_en      = 1'b1;
        set_en       = 1'b1;
        set_idx      = ix_q[IX_FREE];
        wr_ext.start = total_pages + q.n;
        wr_ext.len   = PAGE_W'(inc - {2'b00, q.n});
      end
    end else begin
      if (q.n == '0) begin
        ev_status = ST_OK;
      end else if (rel_end[PAGE_W]) begin
        ev_status = ST_EXHAUSTED;
      end else if (scan_q.nxt_found && ({1'b0, scan_q.nxt_start} < rel_end)) begin
        ev_status = ST_DOUBLE;
      end else if (scan_q.prv_found && (prv_end > {1'b0, q.id})) begin
        ev_status = ST_DOUBLE;
      end else begin
        // lowest free index, counting slots freed by the merge
        if (scan_q.free_found) begin
          have_slot = 1'b1;
          slot      = ix_q[IX_FREE];
        end
        if (mrg_n && (!have_slot || ix_q[IX_NXT] < slot)) begin
          have_slot = 1'b1;
          slot      = ix_q[IX_NXT];
        end
        if (mrg_p && (!have_slot || ix_q[IX_PRV] < slot)) begin
          have_slot = 1'b1;
          slot      = ix_q[IX_PRV];
        end
        if (!have_slot) begin
          ev_status = ST_FULL;
        end else begin
          set_en       = 1'b1;
          set_idx      = slot;
          wr_ext.start = mrg_p ? scan_q.prv_start : q.id;
          wr_ext.len   = q.n + (mrg_n ? scan_q.nxt_len : '0) +
                         (mrg_p ? scan_q.prv_len : '0);
          clr_a_en     = mrg_n && (ix_q[IX_NXT] != slot);
          clr_a_idx    = ix_q[IX_NXT];
          clr_b_en     = mrg_p && (ix_q[IX_PRV] != slot);
          clr_b_idx    = ix_q[IX_PRV];
        end
      end
    end

    if (state != S_EVAL) begin
      set_en   = 1'b0;
      clr_a_en = 1'b0;
      clr_b_en = 1'b0;
      grow_en  = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept_in) state_next = S_SCAN;
      S_SCAN: if (scan_done && div_a_done && div_b_done) state_next = S_MUL;
      S_MUL:  state_next = S_EVAL;
      S_EVAL: state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      scan_done     <= 1'b0;
      launch        <= 1'b0;
      total_pages   <= '0;
      stamp_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept_in;
      if (accept_in) begin
        scan_done <= 1'b0;
      end else if (tok_chain[MAX_EXTENTS].live) begin
        scan_done <= 1'b1;
      end
      if (grow_en) begin
        total_pages <= grow_sum[PAGE_W-1:0];
      end
      if (set_en) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      q.op <= opcode;
      q.id <= page_id;
      q.n  <= page_count;
    end
    if (tok_chain[MAX_EXTENTS].live) begin
      scan_q <= tok_chain[MAX_EXTENTS];
      ix_q   <= ix_chain[MAX_EXTENTS];
    end
    if (state == S_MUL) begin
      inc <= INCW'(amax * GW'(GROWTH_UNIT));
    end
    if (state == S_EVAL) begin
      res_first  <= ev_first;
      res_status <= ev_status;
    end
    if (state == S_FIN && out_free) begin
      first_page      <= res_first;
      status          <= res_status;
      total_pages_now <= total_pages;
    end
  end

  // failed requests never hand out a page
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_DOUBLE || status == ST_FULL ||
                   status == ST_EXHAUSTED)) |-> (first_page == '0))
    else $error("failed request returned a page");

  // the space only changes in the evaluate step
  a_total_eval: assert property (@(posedge clk) disable iff (rst)
    (total_pages != $past(total_pages)) |-> ($past(state) == S_EVAL))
    else $error("total_pages changed outside evaluation");

  // scan token leaves the chain only while a scan is running
  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    tok_chain[MAX_EXTENTS].live |-> (state == S_SCAN))
    else $error("stray scan token");

endmodule

`default_nettype wire
